[rtl/core/sad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sad_pkg;

   // byte1 bit positions
   localparam int unsigned HeightHi   = 7;
   localparam int unsigned HeightLo   = 6;
   localparam int unsigned TileBit7   = 5;
   localparam int unsigned XHighBit   = 4;
   localparam int unsigned ColourHi   = 3;

   // height select codes
   localparam logic [1:0] HeightOne  = 2'd0;
   localparam logic [1:0] HeightTwo  = 2'd1;

   // highest part index for each part count
   localparam logic [1:0] TopOne  = 2'd0;
   localparam logic [1:0] TopTwo  = 2'd1;
   localparam logic [1:0] TopFour = 2'd3;

   // mirror origin of flipped screen and x high offset
   localparam logic signed [9:0] FlipOrigin = 10'sd240;
   localparam logic signed [9:0] XHighOffset = 10'sd256;

   // decoded sprite entry
   typedef struct packed {
      logic [8:0]        tile;
      logic [3:0]        colour;
      logic signed [9:0] sx;
      logic signed [9:0] sy;
      logic [1:0]        top;
      logic              flipped;
   } cmd_type;

   // one draw command
   typedef struct packed {
      logic [9:0]        tile;
      logic [3:0]        colour;
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic              flipped;
      logic              last;
   } part_type;

endpackage

`default_nettype wire

[rtl/core/sad_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sad_front (
   input  wire logic [7:0]      attr_byte0,
   input  wire logic [7:0]      attr_byte1,
   input  wire logic [7:0]      attr_byte2,
   input  wire logic [7:0]      attr_byte3,
   input  wire logic            screen_flipped,
   output sad_pkg::cmd_type     cmd
);

   logic signed [9:0] sx_raw;
   logic signed [9:0] sy_raw;

   // raw coordinates, x high flag moves the sprite left by 256
   always_comb begin
      sx_raw = $signed({2'b00, attr_byte3})
         - (attr_byte1[sad_pkg::XHighBit] ? sad_pkg::XHighOffset : 10'sd0);
      sy_raw = $signed({2'b00, attr_byte2});
   end

   // classify entry into a command for the back end
   always_comb begin
      cmd.tile    = {attr_byte0[7], attr_byte1[sad_pkg::TileBit7], attr_byte0[6:0]};
      cmd.colour  = attr_byte1[sad_pkg::ColourHi:0];
      cmd.flipped = screen_flipped;
      if (screen_flipped) begin
         cmd.sx = sad_pkg::FlipOrigin - sx_raw;
         cmd.sy = sad_pkg::FlipOrigin - sy_raw;
      end else begin
         cmd.sx = sx_raw;
         cmd.sy = sy_raw;
      end
      case (attr_byte1[sad_pkg::HeightHi:sad_pkg::HeightLo])
         sad_pkg::HeightOne: cmd.top = sad_pkg::TopOne;
         sad_pkg::HeightTwo: cmd.top = sad_pkg::TopTwo;
         default:            cmd.top = sad_pkg::TopFour;
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/sad_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sad_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_valid,
   input  wire sad_pkg::cmd_type wr_cmd,
   output logic                 full,
   output logic                 rd_valid,
   input  wire logic            rd_ready,
   output sad_pkg::cmd_type     rd_cmd
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   sad_pkg::cmd_type mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push;
   logic             pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && !full;
   assign pop      = rd_valid && rd_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/core/sad_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sad_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   input  wire sad_pkg::cmd_type cmd,
   output logic                 cmd_ready,
   output logic                 part_valid,
   input  wire logic            part_ready,
   output sad_pkg::part_type    part
);

   sad_pkg::cmd_type  cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic [1:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   sad_pkg::part_type out_ff, out_in;
   logic              emit;
   logic              emit_last;
   logic              load;
   logic signed [9:0] offset;

   assign emit      = busy_ff && (!out_valid_ff || part_ready);
   assign emit_last = emit && (idx_ff == 2'd0);
   assign cmd_ready = !busy_ff || emit_last;
   assign load      = cmd_valid && cmd_ready;
   assign offset    = $signed({4'b0000, idx_ff, 4'b0000});

   // part sequencer, highest index first
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         cur_in  = cmd;
         busy_in = 1'b1;
         idx_in  = cmd.top;
      end else if (emit) begin
         busy_in = !emit_last;
         idx_in  = idx_ff - 1'b1;
      end
   end

   // build the current part
   always_comb begin
      out_in.tile    = {1'b0, cur_ff.tile} + {8'b0, idx_ff};
      out_in.colour  = cur_ff.colour;
      out_in.x       = cur_ff.sx;
      out_in.y       = cur_ff.flipped ? cur_ff.sy - offset : cur_ff.sy + offset;
      out_in.flipped = cur_ff.flipped;
      out_in.last    = (idx_ff == 2'd0);
   end

   // output register
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (part_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign part_valid = out_valid_ff;
   assign part       = out_ff;

endmodule

`default_nettype wire

[rtl/core/sprite_attribute_decoder.sv]
// entries pass the queue storage, the back end command register, then its output register
// throughput: one part per cycle while rsp_tready is high; 1, 2 or 4 parts per entry
//   by its height, set by the part sequencer in the back end
// the command queue lets the front take new requests while the back is still emitting
// reset: synchronous active high, clears queue, sequencer, output valid and screen flip
`timescale 1ns / 1ps
`default_nettype none

module sprite_attribute_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // attr_byte0 [7:0], attr_byte1 [15:8], attr_byte2 [23:16], attr_byte3 [31:24]
   input  wire logic [31:0] req_tdata,
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // part_tile [9:0], part_colour [13:10], part_x [23:14], part_y [33:24], zero [39:34]
   output logic [39:0]      rsp_tdata,
   // part_flipped [0]
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   logic              flip_ff, flip_in;
   sad_pkg::cmd_type  front_cmd;
   sad_pkg::cmd_type  queue_cmd;
   logic              queue_full;
   logic              queue_valid;
   logic              queue_ready;
   logic              part_valid;
   sad_pkg::part_type part;

   // screen flip register
   assign flip_in = csr_wr_en ? csr_wr_data : flip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else begin
         flip_ff <= flip_in;
      end
   end

   // front end decode
   sad_front u_front (
      .attr_byte0     (req_tdata[7:0]),
      .attr_byte1     (req_tdata[15:8]),
      .attr_byte2     (req_tdata[23:16]),
      .attr_byte3     (req_tdata[31:24]),
      .screen_flipped (flip_ff),
      .cmd            (front_cmd)
   );

   // command queue between front and back
   sad_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_cmd   (front_cmd),
      .full     (queue_full),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_cmd   (queue_cmd)
   );

   assign req_tready = !queue_full;

   // back end part sequencer
   sad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (queue_cmd),
      .cmd_ready  (queue_ready),
      .part_valid (part_valid),
      .part_ready (rsp_tready),
      .part       (part)
   );

   // result packing
   assign rsp_tvalid = part_valid;
   assign rsp_tdata  = {6'b000000, part.y, part.x, part.colour, part.tile};
   assign rsp_tuser  = part.flipped;
   assign rsp_tlast  = part.last;

`ifndef SYNTHESIS
   // parts of one entry follow without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("part sequence broken");

   // tile steps down by one between parts of one entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tdata[9:0] == $past(rsp_tdata[9:0]) - 10'd1))
      else $error("part tile not descending");

   // flip flag and colour stay the same within one entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tuser == $past(rsp_tuser)) && (rsp_tdata[13:10] == $past(rsp_tdata[13:10])))
      else $error("entry attributes changed between parts");
`endif

endmodule

`default_nettype wire
